// File: hw/rtl/cdf_pkg.sv
// Shared types and constants for the camera dead-zone follower.
`default_nettype none
package cdf_pkg;

	// Default viewport size in pixels.
	localparam int SCREEN_WIDTH_DEF = 1280;
	localparam int SCREEN_HEIGHT_DEF = 720;

	// Register reset values.
	localparam logic [23:0] ZOOM_RST = 24'd65536;
	localparam logic [16:0] TILT_RST = 17'd65536;
	localparam logic [63:0] DZ_RST = {32'd160 << 16, 32'd90 << 16};
	localparam logic [16:0] STIFF_RST = 17'd11796;

	// Tilt and stiffness limits, Q1.16.
	localparam logic [16:0] TILT_MIN = 17'd6554;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Operations of the shared serial arithmetic unit.
	typedef enum logic [1:0] {
		AOP_MUL,
		AOP_DIV,
		AOP_SQRT
	} aop_t;

	// Request to the arithmetic unit; a pulse on go starts it.
	typedef struct packed {
		logic go;
		aop_t op;
		logic [63:0] a;
		logic [63:0] b;
		logic [6:0] cnt;
	} arith_req_t;

	// Response: done pulses for one cycle with the result held.
	typedef struct packed {
		logic done;
		logic [63:0] result;
	} arith_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/camera_deadzone_follow.sv
// Camera dead-zone follower top level: configuration, sequencer and result register.
// Usage: an input beat on in_valid/in_stall carries one operation. A load sets the
// camera position from target_x/target_y; a follow tick moves the camera toward
// the target beyond the dead zone, limits the move to max_speed * time_step if set and
// clamps it to the world bounds if on. Each input beat yields exactly one output beat
// on out_valid/out_stall with the new position and two flags.
// A load or a tick with follow_on low goes from the idle state through S_OUT into
// the output register. A tick runs its steps through one shared bit-serial unit,
// one bit per cycle: two dead-zone divisions and two stiffness products; a speed
// limit adds products, a 32-step square root and, when it applies, two 64-step
// divisions, and bounds that are on add three divisions. Items are worked one at a
// time. in_stall is high while an item is in work. A finished result waits in the
// output register while out_stall is high; the next item may be accepted meanwhile.
// Reset clears the position to zero and loads the register defaults.
// The user must write configuration through the APB port only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module camera_deadzone_follow #(
	parameter int SCREEN_WIDTH = cdf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = cdf_pkg::SCREEN_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	// Configuration port.
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [5:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	// Input channel.
	input logic in_valid,
	output logic in_stall,
	input logic operation,
	input logic signed [31:0] target_x,
	input logic signed [31:0] target_y,
	input logic signed [31:0] time_step,
	input logic follow_on,
	// Output channel.
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] camera_x,
	output logic signed [31:0] camera_y,
	output logic speed_limited,
	output logic bound_hit
);
	import cdf_pkg::*;

	// Dividend widths of the viewport divisions.
	localparam int VXW = $clog2(SCREEN_WIDTH + 1) + 31;
	localparam int VYW = $clog2(SCREEN_HEIGHT + 1) + 31;
	localparam int VY2W = VYW + 16;
	localparam logic [63:0] VX_DIV = 64'(SCREEN_WIDTH) << (95 - VXW);
	localparam logic [63:0] VY_DIV = 64'(SCREEN_HEIGHT) << (95 - VYW);

	typedef enum logic [2:0] {
		R_ZOOM_X, R_ZOOM_Y, R_TILT, R_DZ, R_STIFF, R_MSPD, R_BORG, R_BEXT
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_HWX, S_HWY, S_EX, S_MSX, S_MSY, S_MMS, S_SQX, S_SQY, S_SQRT,
		S_NX, S_DX, S_NY, S_DY, S_POS, S_VX, S_VY1, S_VY2, S_BLO, S_BCL, S_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// Configuration registers.
	logic [23:0] zoom_x_q, zoom_y_q;
	logic [16:0] tilt_q, stiff_q;
	logic [63:0] dz_q, borg_q, bext_q;
	logic [30:0] mspd_q;
	logic cfg_wr;
	reg_idx_t cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_x_q <= ZOOM_RST;
			zoom_y_q <= ZOOM_RST;
			tilt_q <= TILT_RST;
			dz_q <= DZ_RST;
			stiff_q <= STIFF_RST;
			mspd_q <= '0;
			borg_q <= '0;
			bext_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				R_ZOOM_X: zoom_x_q <= pwdata[23:0];
				R_ZOOM_Y: zoom_y_q <= pwdata[23:0];
				R_TILT: tilt_q <= pwdata[16:0];
				R_DZ: dz_q <= pwdata;
				R_STIFF: stiff_q <= pwdata[16:0];
				R_MSPD: mspd_q <= pwdata[30:0];
				R_BORG: borg_q <= pwdata;
				R_BEXT: bext_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (cfg_idx)
			R_ZOOM_X: prdata = 64'(zoom_x_q);
			R_ZOOM_Y: prdata = 64'(zoom_y_q);
			R_TILT: prdata = 64'(tilt_q);
			R_DZ: prdata = dz_q;
			R_STIFF: prdata = 64'(stiff_q);
			R_MSPD: prdata = 64'(mspd_q);
			R_BORG: prdata = borg_q;
			R_BEXT: prdata = bext_q;
			default: prdata = '0;
		endcase
	end

	// Sanitized register values.
	logic [23:0] zx, zy;
	logic [16:0] tl, st;
	logic bon;
	assign zx = (zoom_x_q == '0) ? 24'd1 : zoom_x_q;
	assign zy = (zoom_y_q == '0) ? 24'd1 : zoom_y_q;
	assign tl = (tilt_q < TILT_MIN) ? TILT_MIN : ((tilt_q > ONE_Q16) ? ONE_Q16 : tilt_q);
	assign st = (stiff_q > ONE_Q16) ? ONE_Q16 : stiff_q;
	assign bon = (bext_q[63:32] != '0) && (bext_q[31:0] != '0);

	// Sequencer state and working registers.
	state_t state_q;
	logic issued_q;
	arith_req_t req_q;
	arith_rsp_t rsp;
	logic signed [31:0] tx_q, ty_q, dt_q, px_q, py_q;
	logic [47:0] hwx_q, hwy_q;
	logic [33:0] mgx_q, mgy_q;
	logic sgx_q, sgy_q, sh_q, ax_q, lim_q, hit_q;
	logic [45:0] mstep_q;
	logic [63:0] sq_q, vhx_q, vhy_q;
	logic [31:0] ls_q;
	logic signed [63:0] cx_q, cy_q, lo_q, hi_q;
	logic out_valid_q;
	logic signed [31:0] cam_x_q, cam_y_q;
	logic lim_out_q, hit_out_q;

	cdf_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_q),
		.rsp(rsp)
	);

	// Dead-zone excess per axis.
	logic signed [32:0] dx, dy;
	logic [32:0] adx, ady, exx, exy;
	assign dx = {tx_q[31], tx_q} - {px_q[31], px_q};
	assign dy = {ty_q[31], ty_q} - {py_q[31], py_q};
	assign adx = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady = dy[32] ? 33'(-dy) : 33'(dy);
	assign exx = ({15'b0, adx} > hwx_q) ? 33'({15'b0, adx} - hwx_q) : '0;
	assign exy = ({15'b0, ady} > hwy_q) ? 33'({15'b0, ady} - hwy_q) : '0;

	// Shifted step magnitudes for the speed limit.
	logic [33:0] mxs, mys;
	logic [31:0] dt_pos;
	logic [32:0] lsh;
	assign mxs = sh_q ? (mgx_q >> 1) : mgx_q;
	assign mys = sh_q ? (mgy_q >> 1) : mgy_q;
	assign dt_pos = dt_q[31] ? '0 : dt_q;
	assign lsh = sh_q ? {rsp.result[31:0], 1'b0} : {1'b0, rsp.result[31:0]};

	// Signed move per axis.
	logic signed [63:0] stepx, stepy;
	assign stepx = sgx_q ? -$signed({30'b0, mgx_q}) : $signed({30'b0, mgx_q});
	assign stepy = sgy_q ? -$signed({30'b0, mgy_q}) : $signed({30'b0, mgy_q});

	// Bounds for the current axis and the clamp.
	logic signed [63:0] b0, bext, bvh, cv, cr;
	logic clen;
	assign b0 = ax_q ? {{32{borg_q[31]}}, borg_q[31:0]} : {{32{borg_q[63]}}, borg_q[63:32]};
	assign bext = ax_q ? {32'b0, bext_q[31:0]} : {32'b0, bext_q[63:32]};
	assign bvh = ax_q ? $signed(vhy_q) : $signed(vhx_q);
	assign cv = ax_q ? cy_q : cx_q;
	assign clen = bon && (lo_q <= hi_q);
	assign cr = !clen ? cv : ((cv < lo_q) ? lo_q : ((cv > hi_q) ? hi_q : cv));

	assign in_stall = (state_q != S_IDLE);

	// Main sequencer: one step of the tick per state, arithmetic on the shared unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			req_q.go <= 1'b0;
			out_valid_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
		end else begin
			// Clear the start pulse once a request has been issued.
			if (issued_q) req_q.go <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != S_OUT)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						tx_q <= target_x;
						ty_q <= target_y;
						dt_q <= time_step;
						lim_q <= 1'b0;
						hit_q <= 1'b0;
						ax_q <= 1'b0;
						if (operation) begin
							px_q <= target_x;
							py_q <= target_y;
							state_q <= S_OUT;
						end else if (!follow_on) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_HWX;
						end
					end
				end
				S_HWX: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: {dz_q[63:32], 32'b0},
							b: 64'(zx), cnt: 7'd48};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						hwx_q <= rsp.result[47:0];
						state_q <= S_HWY;
					end
				end
				S_HWY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: {dz_q[31:0], 32'b0},
							b: 64'(zy), cnt: 7'd48};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						hwy_q <= rsp.result[47:0];
						state_q <= S_EX;
					end
				end
				S_EX: begin
					mgx_q <= {1'b0, exx};
					mgy_q <= {1'b0, exy};
					sgx_q <= dx[32];
					sgy_q <= dy[32];
					state_q <= S_MSX;
				end
				S_MSX: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mgx_q), b: 64'(st),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						mgx_q <= 34'((rsp.result + 64'd32768) >> 16);
						state_q <= S_MSY;
					end
				end
				S_MSY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mgy_q), b: 64'(st),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						mgy_q <= 34'((rsp.result + 64'd32768) >> 16);
						state_q <= (mspd_q == '0) ? S_POS : S_MMS;
					end
				end
				S_MMS: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mspd_q), b: 64'(dt_pos),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						mstep_q <= rsp.result[61:16];
						sh_q <= (mgx_q[33:31] != '0) || (mgy_q[33:31] != '0);
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mxs), b: 64'(mxs),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						sq_q <= rsp.result;
						state_q <= S_SQY;
					end
				end
				S_SQY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mys), b: 64'(mys),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						sq_q <= sq_q + rsp.result;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_SQRT, a: sq_q, b: '0, cnt: 7'd32};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						ls_q <= rsp.result[31:0];
						if ({13'b0, lsh} > mstep_q) begin
							lim_q <= 1'b1;
							state_q <= S_NX;
						end else begin
							state_q <= S_POS;
						end
					end
				end
				S_NX: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mxs), b: 64'(mstep_q),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						sq_q <= rsp.result;
						state_q <= S_DX;
					end
				end
				S_DX: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: sq_q, b: 64'(ls_q), cnt: 7'd64};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						mgx_q <= rsp.result[33:0];
						state_q <= S_NY;
					end
				end
				S_NY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_MUL, a: 64'(mys), b: 64'(mstep_q),
							cnt: 7'd0};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						sq_q <= rsp.result;
						state_q <= S_DY;
					end
				end
				S_DY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: sq_q, b: 64'(ls_q), cnt: 7'd64};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						mgy_q <= rsp.result[33:0];
						state_q <= S_POS;
					end
				end
				S_POS: begin
					cx_q <= {{32{px_q[31]}}, px_q} + stepx;
					cy_q <= {{32{py_q[31]}}, py_q} + stepy;
					state_q <= bon ? S_VX : S_BLO;
				end
				S_VX: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: VX_DIV, b: 64'(zx),
							cnt: 7'(VXW)};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						vhx_q <= rsp.result;
						state_q <= S_VY1;
					end
				end
				S_VY1: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: VY_DIV, b: 64'(zy),
							cnt: 7'(VYW)};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						vhy_q <= rsp.result;
						state_q <= S_VY2;
					end
				end
				S_VY2: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						req_q <= '{go: 1'b1, op: AOP_DIV, a: vhy_q << (64 - VYW),
							b: 64'(tl), cnt: 7'(VY2W)};
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						vhy_q <= rsp.result;
						state_q <= S_BLO;
					end
				end
				S_BLO: begin
					lo_q <= b0 + bvh;
					hi_q <= b0 + bext - bvh;
					state_q <= S_BCL;
				end
				S_BCL: begin
					if (cr != cv) hit_q <= 1'b1;
					if (ax_q) begin
						py_q <= sat32(cr);
						state_q <= S_OUT;
					end else begin
						px_q <= sat32(cr);
						ax_q <= 1'b1;
						state_q <= S_BLO;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						cam_x_q <= px_q;
						cam_y_q <= py_q;
						lim_out_q <= lim_q;
						hit_out_q <= hit_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign camera_x = cam_x_q;
	assign camera_y = cam_y_q;
	assign speed_limited = lim_out_q;
	assign bound_hit = hit_out_q;

	// No arithmetic request is outstanding while idle.
	ap_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !issued_q)
		else $error("request outstanding while idle");
	// Arithmetic results arrive only for a request that was issued.
	ap_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> issued_q)
		else $error("unexpected arithmetic result");
	// The speed limit can only fire when a limit is set.
	ap_lim_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && lim_q) |-> (mspd_q != '0))
		else $error("speed limited without a limit");

endmodule
`default_nettype wire

// File: hw/rtl/cdf_arith.sv
// Bit-serial multiplier, restoring divider and square root shared by the follower.
`default_nettype none
module cdf_arith (
	input logic clk,
	input logic arst_n,
	input cdf_pkg::arith_req_t req,
	output cdf_pkg::arith_rsp_t rsp
);
	import cdf_pkg::*;

	aop_t op_q;
	logic [63:0] a_q, b_q, acc_q, rem_q;
	logic [6:0] cnt_q;
	logic run_q, done_q;
	logic [64:0] drem, ddiff;
	logic [63:0] srem, strial;

	// Divider step: bring down one dividend bit and try the subtract.
	assign drem = {rem_q, a_q[63]};
	assign ddiff = drem - {1'b0, b_q};

	// Square root step: bring down two radicand bits, trial is 4q+1 for the root q so far.
	assign srem = {rem_q[61:0], a_q[63:62]};
	assign strial = {acc_q[61:0], 2'b01};

	// One multiplier bit, quotient bit or root bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				op_q <= req.op;
				a_q <= req.a;
				b_q <= req.b;
				cnt_q <= req.cnt;
				acc_q <= '0;
				rem_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				case (op_q)
					AOP_MUL: begin
						if (b_q == '0) begin
							run_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							if (b_q[0]) acc_q <= acc_q + a_q;
							a_q <= a_q << 1;
							b_q <= b_q >> 1;
						end
					end
					AOP_DIV: begin
						if (!ddiff[64]) begin
							rem_q <= ddiff[63:0];
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= drem[63:0];
							acc_q <= {acc_q[62:0], 1'b0};
						end
						a_q <= a_q << 1;
						cnt_q <= cnt_q - 7'd1;
						if (cnt_q == 7'd1) begin
							run_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					AOP_SQRT: begin
						if (srem >= strial) begin
							rem_q <= srem - strial;
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= srem;
							acc_q <= {acc_q[62:0], 1'b0};
						end
						a_q <= a_q << 2;
						cnt_q <= cnt_q - 7'd1;
						if (cnt_q == 7'd1) begin
							run_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						run_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = acc_q;

	// A request always starts the unit.
	ap_go_runs: assert property (@(posedge clk) disable iff (!arst_n) req.go |=> run_q)
		else $error("arith unit did not start");
	// Completion is reported only once the unit has stopped.
	ap_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !run_q)
		else $error("done while still running");
	// The sequencer never divides by zero.
	ap_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && op_q == AOP_DIV) |-> (b_q != '0))
		else $error("division by zero");

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the camera dead-zone follower, with directed and random phases.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMEOUT_CYCLES = 6000000;
	localparam int REG_ZOOM_X = 0;
	localparam int REG_ZOOM_Y = 1;
	localparam int REG_TILT = 2;
	localparam int REG_DEADZONE = 3;
	localparam int REG_STIFF = 4;
	localparam int REG_MAX_SPEED = 5;
	localparam int REG_BORIGIN = 6;
	localparam int REG_BEXTENT = 7;
	localparam bit OP_TICK = 1'b0;
	localparam bit OP_LOAD = 1'b1;
	localparam logic [31:0] ONE_SEC = 32'h0001_0000;
	localparam logic [31:0] FRAME_DT = 32'd1092;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic lim;
		logic hit;
	} cam_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic operation, follow_on;
	logic signed [31:0] target_x, target_y, time_step;
	logic signed [31:0] camera_x, camera_y;
	logic speed_limited, bound_hit;

	// Shadow of the configuration and the camera position.
	logic [23:0] zoom_x_q, zoom_y_q;
	logic [16:0] tilt_q, stiff_q;
	logic [63:0] dz_q, borg_q, bext_q;
	logic [30:0] speed_q;
	logic signed [31:0] cam_x_q, cam_y_q;

	cam_result_t expected_moves[$];
	int errors;
	int cycles;
	bit no_idle;
	int stall_left;

	camera_deadzone_follow u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.target_x(target_x), .target_y(target_y), .time_step(time_step),
		.follow_on(follow_on),
		.out_valid(out_valid), .out_stall(out_stall), .camera_x(camera_x),
		.camera_y(camera_y), .speed_limited(speed_limited), .bound_hit(bound_hit)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// Stiffness share of the offset beyond the dead zone, rounded on magnitude.
	function automatic longint excess_step(longint d, longint unsigned hw, longint unsigned st);
		longint unsigned m, s;
		m = abs64(d);
		if (m <= hw) return 0;
		s = ((m - hw) * st + 64'd32768) >> 16;
		return d < 0 ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint clamp_axis(longint v, longint lo, longint hi, inout bit hit);
		longint r;
		r = v;
		if (lo <= hi) begin
			if (r < lo) r = lo;
			else if (r > hi) r = hi;
		end
		if (r != v) hit = 1'b1;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Next camera position and flags for one beat; updates the shadow position.
	function automatic cam_result_t predict_camera(bit op, logic signed [31:0] tx,
			logic signed [31:0] ty, logic signed [31:0] ts, bit fo);
		cam_result_t res;
		longint unsigned zx, zy, tl, st, hwx, hwy, max_step, mx, my, ls, nx, ny, bw, bh;
		longint sx, sy, cx, cy, dt, bx, by, vhx, vhy;
		int sh;
		bit lim, hit;
		lim = 1'b0;
		hit = 1'b0;
		if (op == OP_LOAD) begin
			cam_x_q = tx;
			cam_y_q = ty;
		end else if (fo) begin
			zx = zoom_x_q != 0 ? zoom_x_q : 1;
			zy = zoom_y_q != 0 ? zoom_y_q : 1;
			tl = tilt_q < 6554 ? 6554 : (tilt_q > 65536 ? 65536 : tilt_q);
			st = stiff_q > 65536 ? 65536 : stiff_q;
			hwx = (longint'(dz_q[63:32]) << 16) / zx;
			hwy = (longint'(dz_q[31:0]) << 16) / zy;
			sx = excess_step(longint'(tx) - longint'(cam_x_q), hwx, st);
			sy = excess_step(longint'(ty) - longint'(cam_y_q), hwy, st);
			dt = ts < 0 ? 0 : longint'(ts);
			if (speed_q != 0) begin
				max_step = (longint'(speed_q) * dt) >> 16;
				mx = abs64(sx);
				my = abs64(sy);
				sh = (mx >= 64'h8000_0000 || my >= 64'h8000_0000) ? 1 : 0;
				mx >>= sh;
				my >>= sh;
				ls = int_sqrt(mx * mx + my * my);
				if ((ls << sh) > max_step) begin
					nx = mx * max_step / ls;
					ny = my * max_step / ls;
					sx = sx < 0 ? -longint'(nx) : longint'(nx);
					sy = sy < 0 ? -longint'(ny) : longint'(ny);
					lim = 1'b1;
				end
			end
			cx = longint'(cam_x_q) + sx;
			cy = longint'(cam_y_q) + sy;
			bw = bext_q[63:32];
			bh = bext_q[31:0];
			if (bw != 0 && bh != 0) begin
				bx = longint'($signed(borg_q[63:32]));
				by = longint'($signed(borg_q[31:0]));
				vhx = longint'((64'd1280 << 31) / zx);
				vhy = longint'((((64'd720 << 31) / zy) << 16) / tl);
				cx = clamp_axis(cx, bx + vhx, bx + longint'(bw) - vhx, hit);
				cy = clamp_axis(cy, by + vhy, by + longint'(bh) - vhy, hit);
			end
			cam_x_q = sat32(cx);
			cam_y_q = sat32(cy);
		end
		res.cx = cam_x_q;
		res.cy = cam_y_q;
		res.lim = lim;
		res.hit = hit;
		return res;
	endfunction

	// Output side: random stall and comparison of each beat with the oldest expectation.
	always @(posedge clk) begin
		cam_result_t exp_r;
		int g;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_moves.size() == 0) begin
				$display("%t: unexpected result beat x=%h y=%h", $realtime, camera_x, camera_y);
				errors++;
			end else begin
				exp_r = expected_moves.pop_front();
				if (camera_x !== exp_r.cx) begin
					$display("%t: camera_x expected %h actual %h", $realtime, exp_r.cx, camera_x);
					errors++;
				end
				if (camera_y !== exp_r.cy) begin
					$display("%t: camera_y expected %h actual %h", $realtime, exp_r.cy, camera_y);
					errors++;
				end
				if (speed_limited !== exp_r.lim) begin
					$display("%t: speed_limited expected %b actual %b", $realtime, exp_r.lim,
						speed_limited);
					errors++;
				end
				if (bound_hit !== exp_r.hit) begin
					$display("%t: bound_hit expected %b actual %b", $realtime, exp_r.hit,
						bound_hit);
					errors++;
				end
			end
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			g = pick_gap();
			out_stall <= (g != 0);
			stall_left = g == 0 ? 0 : g - 1;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ZOOM_X: zoom_x_q = val[23:0];
			REG_ZOOM_Y: zoom_y_q = val[23:0];
			REG_TILT: tilt_q = val[16:0];
			REG_DEADZONE: dz_q = val;
			REG_STIFF: stiff_q = val[16:0];
			REG_MAX_SPEED: speed_q = val[30:0];
			REG_BORIGIN: borg_q = val;
			REG_BEXTENT: bext_q = val;
			default: ;
		endcase
	endtask

	// Let the input side rest and wait until all results are back.
	task automatic wait_drained();
		@(posedge clk);
		in_valid <= 1'b0;
		while (expected_moves.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Send one input beat after a random gap and record its expected result.
	task automatic send_item(bit op, logic [31:0] tx, logic [31:0] ty, logic [31:0] ts, bit fo);
		int g;
		g = pick_gap();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		operation <= op;
		target_x <= tx;
		target_y <= ty;
		time_step <= ts;
		follow_on <= fo;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_moves.push_back(predict_camera(op, tx, ty, ts, fo));
	endtask

	task automatic write_all(logic [23:0] zx, logic [23:0] zy, logic [16:0] tl,
			logic [63:0] dz, logic [16:0] st, logic [30:0] sp, logic [63:0] bo, logic [63:0] be);
		write_reg(REG_ZOOM_X, 64'(zx));
		write_reg(REG_ZOOM_Y, 64'(zy));
		write_reg(REG_TILT, 64'(tl));
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_STIFF, 64'(st));
		write_reg(REG_MAX_SPEED, 64'(sp));
		write_reg(REG_BORIGIN, bo);
		write_reg(REG_BEXTENT, be);
	endtask

	// Default settings: loads at the extremes, ticks, follow off and a negative step.
	task automatic test_defaults();
		send_item(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, ONE_SEC, 1'b1);
		send_item(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, ONE_SEC, 1'b0);
		send_item(OP_LOAD, 32'h0, 32'h0, 32'h0, 1'b0);
		send_item(OP_TICK, 32'h00A0_0001, 32'hFFA6_0000, FRAME_DT, 1'b1);
		send_item(OP_TICK, 32'h0300_0000, 32'hFD00_0000, 32'h8000_0000, 1'b1);
		send_item(OP_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		wait_drained();
	endtask

	// Odd register values: zero zoom, tilt out of range, stiffness above one,
	// a tight speed limit and bounds on, then bounds with an empty range, then bounds off.
	task automatic test_special_regs();
		write_all(24'd0, 24'hFF_FFFF, 17'd0, 64'h0, 17'h1FFFF, 31'd65536,
			{32'hF000_0000, 32'hF000_0000}, {32'h2000_0000, 32'h2000_0000});
		send_item(OP_LOAD, 32'h0, 32'h0, 32'h0, 1'b1);
		send_item(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, ONE_SEC, 1'b1);
		send_item(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1);
		send_item(OP_TICK, 32'h0010_0000, 32'h0010_0000, 32'h7FFF_FFFF, 1'b1);
		wait_drained();
		write_all(24'hFF_FFFF, 24'd1, 17'h1FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65536,
			31'h7FFF_FFFF, {32'h7FFF_FFFF, 32'h8000_0000}, {32'hFFFF_FFFF, 32'h0000_0001});
		send_item(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, ONE_SEC, 1'b1);
		send_item(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_drained();
		write_reg(REG_BEXTENT, {32'h0, 32'h0100_0000});
		send_item(OP_TICK, 32'h1234_5678, 32'h8765_4321, ONE_SEC, 1'b1);
		wait_drained();
	endtask

	// Random settings for one phase, with the extremes now and then.
	task automatic random_config();
		logic [23:0] zx, zy;
		logic [16:0] tl, st;
		logic [63:0] dz, bo, be;
		logic [30:0] sp;
		zx = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(32768, 262144));
		zy = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(32768, 262144));
		tl = 17'($urandom);
		st = $urandom_range(0, 4) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
		dz = {32'($urandom_range(0, 400 << 16)), 32'($urandom_range(0, 300 << 16))};
		if ($urandom_range(0, 5) == 0) dz = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: sp = 31'd0;
			1: sp = 31'($urandom);
			default: sp = 31'($urandom_range(1 << 16, 3000 << 16));
		endcase
		bo = {32'(-$urandom_range(0, 3000 << 16)), 32'(-$urandom_range(0, 3000 << 16))};
		be = {32'($urandom_range(0, 8000 << 16)), 32'($urandom_range(0, 8000 << 16))};
		if ($urandom_range(0, 4) == 0) bo = {$urandom, $urandom};
		if ($urandom_range(0, 4) == 0) be = {$urandom, $urandom};
		if ($urandom_range(0, 5) == 0) be[31:0] = 32'h0;
		write_all(zx, zy, tl, dz, st, sp, bo, be);
	endtask

	// Random beats: mostly targets near the camera with frame-sized steps.
	task automatic test_random_phase(int n);
		logic [31:0] tx, ty, ts;
		int r;
		no_idle = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			tx = cam_x_q + 32'($signed($urandom_range(0, 1600 << 16)) - (800 << 16));
			ty = cam_y_q + 32'($signed($urandom_range(0, 1000 << 16)) - (500 << 16));
			case ($urandom_range(0, 9))
				0: ts = $urandom;
				1: ts = 32'(-$urandom_range(1, 1 << 16));
				2: ts = 32'($urandom_range(0, 2 << 16));
				default: ts = FRAME_DT + 32'($urandom_range(0, 300));
			endcase
			if (r < 10) send_item(OP_LOAD, $urandom, $urandom, $urandom, 1'($urandom));
			else if (r < 16) send_item(OP_TICK, tx, ty, ts, 1'b0);
			else if (r < 28) send_item(OP_TICK, $urandom, $urandom, ts, 1'b1);
			else send_item(OP_TICK, tx, ty, ts, 1'b1);
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		no_idle = 1'b0;
		stall_left = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		operation = 1'b0;
		target_x = '0;
		target_y = '0;
		time_step = '0;
		follow_on = 1'b0;
		out_stall = 1'b0;
		zoom_x_q = 24'd65536;
		zoom_y_q = 24'd65536;
		tilt_q = 17'd65536;
		dz_q = {32'd160 << 16, 32'd90 << 16};
		stiff_q = 17'd11796;
		speed_q = '0;
		borg_q = '0;
		bext_q = '0;
		cam_x_q = '0;
		cam_y_q = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_defaults();
		test_special_regs();
		for (int p = 0; p < 7; p++) begin
			random_config();
			test_random_phase(270);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
